[design/fr_pkg.sv]
// ---------------------------------------------------------------------------
// fr_pkg
// Shared types and status codes for the Fresnel reflectance pipeline.
// ---------------------------------------------------------------------------
package fr_pkg;

  localparam logic [1:0] ST_FRESNEL = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_TIR     = 2'd2;
  localparam logic [1:0] ST_ZDEN    = 2'd3;

  localparam logic [15:0] REFL_ONE  = 16'd32768;
  localparam logic [15:0] IDX_RESET = 16'd4096;

  // context carried alongside the long arithmetic sections
  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        n1;
    logic [15:0]        n2;
    logic signed [33:0] nc1;
    logic signed [33:0] nc2;
  } ctx_t;

endpackage

[design/fr_cfg_if.sv]
// ---------------------------------------------------------------------------
// fr_cfg_if
// Configuration write channel: material index.
// ---------------------------------------------------------------------------
interface fr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] material_index;

  modport source (output valid, output material_index, input ready);
  modport sink   (input valid, input material_index, output ready);
endinterface

[design/fr_hit_if.sv]
// ---------------------------------------------------------------------------
// fr_hit_if
// Surface hit channel: view vector, normal and incident index.
// ---------------------------------------------------------------------------
interface fr_hit_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] view_x;
  logic signed [15:0] view_y;
  logic signed [15:0] view_z;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [15:0]        incident_index;

  modport source (output valid, output view_x, output view_y, output view_z,
                  output normal_x, output normal_y, output normal_z,
                  output incident_index, input ready);
  modport sink   (input valid, input view_x, input view_y, input view_z,
                  input normal_x, input normal_y, input normal_z,
                  input incident_index, output ready);
endinterface

[design/fr_refl_if.sv]
// ---------------------------------------------------------------------------
// fr_refl_if
// Result channel: reflectance and status.
// ---------------------------------------------------------------------------
interface fr_refl_if;
  logic        valid;
  logic        ready;
  logic [15:0] reflectance;
  logic [1:0]  status;

  modport source (output valid, output reflectance, output status, input ready);
  modport sink   (input valid, input reflectance, input status, output ready);
endinterface

[design/fresnel_reflectance.sv]
// ---------------------------------------------------------------------------
// fresnel_reflectance
// Unpolarized Fresnel reflectance, one hit per cycle, fully pipelined.
// Pipeline: 75 stages, including a 31-stage index-ratio divider, a 16-stage
// square root and 16-stage coefficient dividers. Throughput: one transaction
// per cycle; the whole pipe stalls while the output register holds an untaken
// result.
// Reset: asynchronous, clears all valid bits; material index resets to 1.0.
// ---------------------------------------------------------------------------
module fresnel_reflectance
  import fr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fr_cfg_if.sink    cfg_i,
  fr_hit_if.sink    hit_i,
  fr_refl_if.source refl_o
);

  logic        en;
  logic [15:0] mat_q;

  // ---- config ----
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= IDX_RESET;
    end else if (cfg_i.valid) begin
      mat_q <= cfg_i.material_index;
    end
  end

  // ---- stage valids ----
  localparam int NS = 75;
  logic [NS-1:0] v_q;

  assign en          = !v_q[NS-1] || refl_o.ready;
  assign hit_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], hit_i.valid};
    end
  end

  // ---- S0: input capture ----
  logic signed [15:0] vx_q, vy_q, vz_q, nx_q, ny_q, nz_q;
  logic [15:0]        n1_0_q, n2_0_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q   <= hit_i.view_x;
      vy_q   <= hit_i.view_y;
      vz_q   <= hit_i.view_z;
      nx_q   <= hit_i.normal_x;
      ny_q   <= hit_i.normal_y;
      nz_q   <= hit_i.normal_z;
      n1_0_q <= hit_i.incident_index;
      n2_0_q <= mat_q;
    end
  end

  // ---- S1: products ----
  logic signed [31:0] px_q, py_q, pz_q;
  logic [31:0]        n1sq_1_q, n2sq_1_q;
  logic [15:0]        n1_1_q, n2_1_q;
  logic [1:0]         st_1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q     <= vx_q * nx_q;
      py_q     <= vy_q * ny_q;
      pz_q     <= vz_q * nz_q;
      n1sq_1_q <= n1_0_q * n1_0_q;
      n2sq_1_q <= n2_0_q * n2_0_q;
      n1_1_q   <= n1_0_q;
      n2_1_q   <= n2_0_q;
      st_1_q   <= (n2_0_q == 16'd0) ? ST_FULL : ST_FRESNEL;
    end
  end

  // ---- S2: dot product, clamp, round to Q1.15 ----
  logic signed [33:0] dot_d, dotc_d, bias_d;
  logic signed [17:0] c18_d;
  logic signed [16:0] c_2_q;
  logic [31:0]        n1sq_2_q, n2sq_2_q;
  logic [15:0]        n1_2_q, n2_2_q;
  logic [1:0]         st_2_q;
  always_comb begin
    dot_d = 34'(px_q) + 34'(py_q) + 34'(pz_q);
    if (dot_d > 34'sd268435456) begin
      dotc_d = 34'sd268435456;
    end else if (dot_d < -34'sd268435456) begin
      dotc_d = -34'sd268435456;
    end else begin
      dotc_d = dot_d;
    end
    bias_d = dotc_d + 34'sd268439552;
    c18_d  = $signed({1'b0, bias_d[29:13]}) - 18'sd32768;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_2_q    <= c18_d[16:0];
      n1sq_2_q <= n1sq_1_q;
      n2sq_2_q <= n2sq_1_q;
      n1_2_q   <= n1_1_q;
      n2_2_q   <= n2_1_q;
      st_2_q   <= st_1_q;
    end
  end

  // ---- S3: c^2, n1*c, n2*c ----
  logic signed [33:0] csq_full_d;
  logic [30:0]        csq_3_q;
  logic [31:0]        n1sq_3_q, n2sq_3_q;
  ctx_t               ctx_3_q;
  assign csq_full_d = c_2_q * c_2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      csq_3_q        <= csq_full_d[30:0];
      n1sq_3_q       <= n1sq_2_q;
      n2sq_3_q       <= n2sq_2_q;
      ctx_3_q.status <= st_2_q;
      ctx_3_q.n1     <= n1_2_q;
      ctx_3_q.n2     <= n2_2_q;
      ctx_3_q.nc1    <= $signed({1'b0, n1_2_q}) * c_2_q;
      ctx_3_q.nc2    <= $signed({1'b0, n2_2_q}) * c_2_q;
    end
  end

  // ---- S4: n1^2 * (1 - c^2) ----
  logic [30:0] omc2_d;
  logic [62:0] lhs_4_q;
  logic [31:0] n2sq_4_q;
  ctx_t        ctx_4_q;
  assign omc2_d = 31'h4000_0000 - csq_3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      lhs_4_q  <= n1sq_3_q * omc2_d;
      n2sq_4_q <= n2sq_3_q;
      ctx_4_q  <= ctx_3_q;
    end
  end

  // ---- S5: total internal reflection test, divider entry ----
  logic [62:0] d1_rem [32];
  logic [30:0] d1_q   [32];
  logic [31:0] d1_den [32];
  ctx_t        d1_ctx [32];
  ctx_t        ctx_tir_d;

  always_comb begin
    ctx_tir_d = ctx_4_q;
    if (ctx_4_q.status == ST_FRESNEL && lhs_4_q > {1'b0, n2sq_4_q, 30'd0}) begin
      ctx_tir_d.status = ST_TIR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_rem[0] <= lhs_4_q;
      d1_q[0]   <= '0;
      d1_den[0] <= n2sq_4_q;
      d1_ctx[0] <= ctx_tir_d;
    end
  end

  // ---- sin^2 T = lhs / n2^2, one quotient bit per stage ----
  for (genvar k = 0; k < 31; k++) begin : g_div1
    localparam int I = 30 - k;
    logic [62:0] trial;
    logic        take;
    assign trial = {31'd0, d1_den[k]} << I;
    assign take  = d1_rem[k] >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        d1_rem[k+1] <= take ? d1_rem[k] - trial : d1_rem[k];
        d1_q[k+1]   <= d1_q[k] | (take ? (31'd1 << I) : 31'd0);
        d1_den[k+1] <= d1_den[k];
        d1_ctx[k+1] <= d1_ctx[k];
      end
    end
  end

  // ---- cos T = isqrt(1 - sin^2 T), one result bit per stage ----
  logic [30:0] sq_v   [17];
  logic [31:0] sq_res [17];
  ctx_t        sq_ctx [17];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_v[0]   <= 31'h4000_0000 - d1_q[31];
      sq_res[0] <= '0;
      sq_ctx[0] <= d1_ctx[31];
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_sqrt
    localparam int B = 15 - k;
    logic [31:0] bitv, trial;
    logic        take;
    assign bitv  = 32'd1 << (2 * B);
    assign trial = sq_res[k] + bitv;
    assign take  = {1'b0, sq_v[k]} >= trial;
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_v[k+1]   <= take ? sq_v[k] - trial[30:0] : sq_v[k];
        sq_res[k+1] <= take ? (sq_res[k] >> 1) + bitv : (sq_res[k] >> 1);
        sq_ctx[k+1] <= sq_ctx[k];
      end
    end
  end

  // ---- P1: n2*cT, n1*cT ----
  logic [31:0] b_q, f_q;
  ctx_t        ctx_p1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q      <= sq_ctx[16].n2 * sq_res[16][15:0];
      f_q      <= sq_ctx[16].n1 * sq_res[16][15:0];
      ctx_p1_q <= sq_ctx[16];
    end
  end

  // ---- P2: numerator and denominator magnitudes ----
  logic signed [34:0] num1_d, den1_d, num2_d, den2_d;
  logic signed [34:0] nn1_d, nd1_d, nn2_d, nd2_d;
  logic [33:0]        mn1_q, md1_q, mn2_q, md2_q;
  logic [1:0]         st_p2_q;
  always_comb begin
    num1_d = {ctx_p1_q.nc1[33], ctx_p1_q.nc1} - $signed({3'd0, b_q});
    den1_d = {ctx_p1_q.nc1[33], ctx_p1_q.nc1} + $signed({3'd0, b_q});
    num2_d = {ctx_p1_q.nc2[33], ctx_p1_q.nc2} - $signed({3'd0, f_q});
    den2_d = {ctx_p1_q.nc2[33], ctx_p1_q.nc2} + $signed({3'd0, f_q});
    nn1_d  = num1_d[34] ? -num1_d : num1_d;
    nd1_d  = den1_d[34] ? -den1_d : den1_d;
    nn2_d  = num2_d[34] ? -num2_d : num2_d;
    nd2_d  = den2_d[34] ? -den2_d : den2_d;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mn1_q   <= nn1_d[33:0];
      md1_q   <= nd1_d[33:0];
      mn2_q   <= nn2_d[33:0];
      md2_q   <= nd2_d[33:0];
      st_p2_q <= ctx_p1_q.status;
    end
  end

  // ---- P3: saturation and zero-denominator checks, divider entry ----
  logic [49:0] d2a_rem [17], d2b_rem [17];
  logic [15:0] d2a_q   [17], d2b_q   [17];
  logic [33:0] d2a_den [17], d2b_den [17];
  logic        d2a_sat [17], d2b_sat [17];
  logic [1:0]  d2_st   [17];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2a_rem[0] <= {1'b0, mn1_q, 15'd0};
      d2b_rem[0] <= {1'b0, mn2_q, 15'd0};
      d2a_q[0]   <= '0;
      d2b_q[0]   <= '0;
      d2a_den[0] <= md1_q;
      d2b_den[0] <= md2_q;
      d2a_sat[0] <= {1'b0, mn1_q} >= {md1_q, 1'b0};
      d2b_sat[0] <= {1'b0, mn2_q} >= {md2_q, 1'b0};
      d2_st[0]   <= (st_p2_q == ST_FRESNEL && (md1_q == '0 || md2_q == '0))
                    ? ST_ZDEN : st_p2_q;
    end
  end

  // ---- |r| = |num| * 2^15 / |den|, one quotient bit per stage ----
  for (genvar k = 0; k < 16; k++) begin : g_div2
    localparam int I = 15 - k;
    logic [49:0] trial_a, trial_b;
    logic        take_a, take_b;
    assign trial_a = {16'd0, d2a_den[k]} << I;
    assign trial_b = {16'd0, d2b_den[k]} << I;
    assign take_a  = d2a_rem[k] >= trial_a;
    assign take_b  = d2b_rem[k] >= trial_b;
    always_ff @(posedge clk_i) begin
      if (en) begin
        d2a_rem[k+1] <= take_a ? d2a_rem[k] - trial_a : d2a_rem[k];
        d2b_rem[k+1] <= take_b ? d2b_rem[k] - trial_b : d2b_rem[k];
        d2a_q[k+1]   <= d2a_q[k] | (take_a ? (16'd1 << I) : 16'd0);
        d2b_q[k+1]   <= d2b_q[k] | (take_b ? (16'd1 << I) : 16'd0);
        d2a_den[k+1] <= d2a_den[k];
        d2b_den[k+1] <= d2b_den[k];
        d2a_sat[k+1] <= d2a_sat[k];
        d2b_sat[k+1] <= d2b_sat[k];
        d2_st[k+1]   <= d2_st[k];
      end
    end
  end

  // ---- Q1: squared coefficients ----
  logic [16:0] r1_d, r2_d;
  logic [33:0] s1_q, s2_q;
  logic [1:0]  st_q1_q;
  assign r1_d = d2a_sat[16] ? 17'h1_0000 : {1'b0, d2a_q[16]};
  assign r2_d = d2b_sat[16] ? 17'h1_0000 : {1'b0, d2b_q[16]};
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= r1_d * r1_d;
      s2_q    <= r2_d * r2_d;
      st_q1_q <= d2_st[16];
    end
  end

  // ---- Q2: mean, round, saturate; output register ----
  logic [34:0] sum_d;
  logic [15:0] refl_q;
  logic [1:0]  st_out_q;
  assign sum_d = {1'b0, s1_q} + {1'b0, s2_q} + 35'd32768;
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_out_q <= st_q1_q;
      if (st_q1_q != ST_FRESNEL || sum_d[34:16] > {3'd0, REFL_ONE}) begin
        refl_q <= REFL_ONE;
      end else begin
        refl_q <= sum_d[31:16];
      end
    end
  end

  assign refl_o.valid       = v_q[NS-1];
  assign refl_o.reflectance = refl_q;
  assign refl_o.status      = st_out_q;

endmodule
